// File: hw/rtl/bfo_pkg.sv
// shared constants for the balance feedback and odometry block
`default_nettype none

package bfo_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_WHEEL_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD      = 3'd4;

	// register reset values
	localparam logic signed [15:0] RST_GAIN_POSITION    = 16'sd256;
	localparam logic signed [15:0] RST_GAIN_PITCH       = 16'sd512;
	localparam logic signed [15:0] RST_GAIN_WHEEL_SPEED = 16'sd768;
	localparam logic signed [15:0] RST_GAIN_PITCH_RATE  = 16'sd1024;
	localparam logic [15:0]        RST_TICK_PERIOD      = 16'd655;

	// wheel radius / (track * 2 pi) and wheel radius / 2, both Q0.24
	localparam logic signed [20:0] HEAD_K = 21'sd644525;
	localparam logic signed [20:0] VEL_K  = 21'sd293601;

	// pi/2 in Q2.30 and one in Q2.30 for the sine series
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint Q30_ONE     = 64'sd1073741824;

	// sine magnitude for a full quarter turn
	localparam logic signed [16:0] SINE_FULL = 17'sd32768;

endpackage

`default_nettype wire

// File: hw/rtl/balance_feedback_with_odometry.sv
// balance feedback with differential-drive odometry, top level
//
// channels: item_valid/item_stall carries one control tick (two wheel speeds,
// pitch, pitch rate); result_valid/result_stall carries the two drive values,
// position and heading after that tick. a transaction happens at a rising
// edge with valid high and stall low. cfg_valid/cfg_ready writes one gain or
// the tick period by index; cfg_ready is always high. the user is to make
// writes only while idle; the block does not enforce it. every product goes
// through one shared 34x21 signed multiplier under a 15-state sequencer, with
// its result registered before use. item_stall is high from an accepted item
// until the sequencer is idle, so a new item is only taken after that. the
// sine/cosine come from a constant quarter-wave rom with a registered read.
// the result sits in an output register; the next item can be taken while
// it waits. if the receiver stalls, a second finished item holds in the last
// sequencer step until the output register frees up.
// reset clears heading and position, loads the default gains and period;
// the rom is a constant, so no fill pass follows reset.
`default_nettype none

module balance_feedback_with_odometry
	import bfo_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        item_valid,
	output logic                       item_stall,
	input  wire  signed [15:0]         wheel_speed_a,
	input  wire  signed [15:0]         wheel_speed_b,
	input  wire  signed [15:0]         pitch_angle,
	input  wire  signed [15:0]         pitch_rate,
	output logic                       result_valid,
	input  wire                        result_stall,
	output logic signed [31:0]         drive_first,
	output logic signed [31:0]         drive_second,
	output logic signed [31:0]         pos_x,
	output logic signed [31:0]         pos_y,
	output logic        [15:0]         heading,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire         [CFG_IDX_W-1:0] cfg_index,
	input  wire         [15:0]         cfg_data
);

	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SCL_W  = 14 + IDX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_HD   = 4'd1;
	localparam logic [3:0] S_HK   = 4'd2;
	localparam logic [3:0] S_SD   = 4'd3;
	localparam logic [3:0] S_VK   = 4'd4;
	localparam logic [3:0] S_COS  = 4'd5;
	localparam logic [3:0] S_CP   = 4'd6;
	localparam logic [3:0] S_SP   = 4'd7;
	localparam logic [3:0] S_PY   = 4'd8;
	localparam logic [3:0] S_GR   = 4'd9;
	localparam logic [3:0] S_GX   = 4'd10;
	localparam logic [3:0] S_GW1  = 4'd11;
	localparam logic [3:0] S_GW2  = 4'd12;
	localparam logic [3:0] S_D2   = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	// quarter-wave sine by a truncating power series
	function automatic logic [SINE_TABLE_DEPTH*16-1:0] build_sine();
		logic [SINE_TABLE_DEPTH*16-1:0] r;
		longint x;
		longint term;
		longint acc;
		longint e;
		int i;
		int k;
		r = '0;
		for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
			term = x;
			acc = x;
			for (k = 1; k <= 6; k++) begin
				term = (term * x) / Q30_ONE;
				term = (term * x) / Q30_ONE;
				// divide by (2k)(2k+1)
				case (k)
					1: term = -term / 64'sd6;
					2: term = -term / 64'sd20;
					3: term = -term / 64'sd42;
					4: term = -term / 64'sd72;
					5: term = -term / 64'sd110;
					default: term = -term / 64'sd156;
				endcase
				acc = acc + term;
			end
			if (acc < 0) begin
				acc = 0;
			end
			e = (acc + 64'sd16384) >>> 15;
			if (e > 64'sd32767) begin
				e = 64'sd32767;
			end
			r[i*16 +: 16] = e[15:0];
		end
		return r;
	endfunction

	localparam logic [SINE_TABLE_DEPTH*16-1:0] SINE_ROM = build_sine();

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		if (v > 56'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -56'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// control
	logic [3:0]  state_q;
	logic        result_valid_q;

	// configuration
	logic signed [15:0] gain_position_q;
	logic signed [15:0] gain_pitch_q;
	logic signed [15:0] gain_wheel_speed_q;
	logic signed [15:0] gain_pitch_rate_q;
	logic        [15:0] tick_period_q;

	// odometry state
	logic        [15:0] heading_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;

	// working registers
	logic signed [15:0] wa_q;
	logic signed [15:0] wb_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] rate_q;
	logic signed [54:0] prod_q;
	logic signed [31:0] p_q;
	logic signed [16:0] cs_q;
	logic        [15:0] rom_q;
	logic               full_q;
	logic               neg_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] drive_first_w_q;
	logic signed [31:0] drive_second_w_q;

	// output register
	logic signed [31:0] drive_first_q;
	logic signed [31:0] drive_second_q;
	logic signed [31:0] pos_x_out_q;
	logic signed [31:0] pos_y_out_q;
	logic        [15:0] heading_out_q;

	// shared multiplier
	logic signed [33:0] op_a;
	logic signed [20:0] op_b;
	logic signed [54:0] prod_d;

	logic signed [16:0] diff;
	logic signed [17:0] negsum;

	// rom addressing
	logic        [15:0]       rom_angle;
	logic        [SCL_W-1:0]  scaled;
	logic        [IDX_W-1:0]  idx;
	logic        [IDX_W-1:0]  sel;
	logic        [ADDR_W-1:0] rom_addr;
	logic                     rom_full;

	logic signed [16:0] mag;
	logic signed [16:0] cs_d;

	logic signed [54:0] head_sum;
	logic signed [54:0] p_sum;
	logic signed [55:0] pos_delta;
	logic signed [55:0] pos_new;
	logic signed [55:0] drive_sum;
	logic signed [55:0] drive_rnd;
	logic               accept;
	logic               out_free;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign cfg_ready  = 1'b1;

	assign diff   = 17'(wa_q) - 17'(wb_q);
	assign negsum = -(18'(wa_q) + 18'(wb_q));

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_HD: begin
				op_a = 34'(diff);
				op_b = 21'(tick_period_q);
			end
			S_HK: begin
				op_a = prod_q[33:0];
				op_b = HEAD_K;
			end
			S_SD: begin
				op_a = 34'(negsum);
				op_b = 21'(tick_period_q);
			end
			S_VK: begin
				op_a = prod_q[33:0];
				op_b = VEL_K;
			end
			S_CP, S_SP: begin
				op_a = 34'(p_q);
				op_b = 21'(cs_q);
			end
			S_PY: begin
				op_a = 34'(pitch_q);
				op_b = 21'(gain_pitch_q);
			end
			S_GR: begin
				op_a = 34'(rate_q);
				op_b = 21'(gain_pitch_rate_q);
			end
			S_GX: begin
				op_a = 34'(pos_x_q);
				op_b = 21'(gain_position_q);
			end
			S_GW1: begin
				op_a = 34'(wb_q);
				op_b = 21'(gain_wheel_speed_q);
			end
			S_GW2: begin
				op_a = 34'(wa_q);
				op_b = 21'(gain_wheel_speed_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_d = op_a * op_b;

	// cosine is sine a quarter turn ahead
	assign rom_angle = (state_q == S_VK) ? heading_q + 16'h4000 : heading_q;
	assign scaled    = SCL_W'(rom_angle[13:0]) * SCL_W'(SINE_TABLE_DEPTH);
	assign idx       = scaled[14 +: IDX_W];
	assign sel       = rom_angle[14] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
	assign rom_full  = (sel == IDX_W'(SINE_TABLE_DEPTH));
	assign rom_addr  = sel[ADDR_W-1:0];

	assign mag  = full_q ? SINE_FULL : signed'({1'b0, rom_q});
	assign cs_d = neg_q ? -mag : mag;

	// round half up at the binary point of the heading step, velocity, position steps and drives
	assign head_sum  = prod_q + 55'sd2147483648;
	assign p_sum     = prod_q + 55'sd8388608;
	assign pos_delta = (56'(prod_q) + 56'sd4194304) >>> 23;
	assign pos_new   = (state_q == S_SP) ? 56'(pos_x_q) + pos_delta
	                                     : 56'(pos_y_q) + pos_delta;
	assign drive_sum = 56'(acc_q) + (56'(prod_q) <<< 8) + 56'sd128;
	assign drive_rnd = drive_sum >>> 8;

	// rom read, registered
	always_ff @(posedge clk) begin
		if (state_q == S_VK || state_q == S_COS) begin
			rom_q  <= SINE_ROM[{rom_addr, 4'b0000} +: 16];
			full_q <= rom_full;
			neg_q  <= rom_angle[15];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_position_q    <= RST_GAIN_POSITION;
			gain_pitch_q       <= RST_GAIN_PITCH;
			gain_wheel_speed_q <= RST_GAIN_WHEEL_SPEED;
			gain_pitch_rate_q  <= RST_GAIN_PITCH_RATE;
			tick_period_q      <= RST_TICK_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_POSITION:    gain_position_q    <= cfg_data;
				REG_GAIN_PITCH:       gain_pitch_q       <= cfg_data;
				REG_GAIN_WHEEL_SPEED: gain_wheel_speed_q <= cfg_data;
				REG_GAIN_PITCH_RATE:  gain_pitch_rate_q  <= cfg_data;
				REG_TICK_PERIOD:      tick_period_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			heading_q      <= '0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HD;
					end
				end
				S_SD: begin
					heading_q <= heading_q + head_sum[47:32];
					state_q   <= S_VK;
				end
				S_SP: begin
					pos_x_q <= sat32(pos_new);
					state_q <= S_PY;
				end
				S_PY: begin
					pos_y_q <= sat32(pos_new);
					state_q <= S_GR;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= state_q + 4'd1;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			wa_q    <= wheel_speed_a;
			wb_q    <= wheel_speed_b;
			pitch_q <= pitch_angle;
			rate_q  <= pitch_rate;
		end
		if (state_q != S_IDLE && state_q != S_OUT) begin
			prod_q <= prod_d;
		end
		case (state_q)
			S_COS: begin
				p_q  <= 32'(p_sum >>> 24);
				cs_q <= cs_d;
			end
			S_CP: begin
				cs_q <= cs_d;
			end
			S_GR: begin
				acc_q <= 48'(prod_q) <<< 4;
			end
			S_GX: begin
				acc_q <= acc_q + (48'(prod_q) <<< 8);
			end
			S_GW1: begin
				acc_q <= acc_q + 48'(prod_q);
			end
			S_GW2: begin
				drive_first_w_q <= sat32(drive_rnd);
			end
			S_OUT: begin
				if (out_free) begin
					drive_first_q  <= drive_first_w_q;
					drive_second_q <= drive_second_w_q;
					pos_x_out_q    <= pos_x_q;
					pos_y_out_q    <= pos_y_q;
					heading_out_q  <= heading_q;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_D2) begin
			drive_second_w_q <= sat32(drive_rnd);
		end
	end

	assign result_valid = result_valid_q;
	assign drive_first  = drive_first_q;
	assign drive_second = drive_second_q;
	assign pos_x        = pos_x_out_q;
	assign pos_y        = pos_y_out_q;
	assign heading      = heading_out_q;

endmodule

`default_nettype wire

// File: hw/rtl/bfo_checker.sv
// port-level checks for the balance feedback and odometry block, with bind
`default_nettype none

module bfo_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               item_valid,
	input wire               item_stall,
	input wire               result_valid,
	input wire               result_stall,
	input wire signed [31:0] drive_first,
	input wire signed [31:0] drive_second,
	input wire signed [31:0] pos_x,
	input wire signed [31:0] pos_y,
	input wire        [15:0] heading
);

	// an accepted tick keeps the input side busy right after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall ##1 item_stall ##1 item_stall)
		else $error("input taken again too soon after a transaction");

	// a result only appears at the end of a busy stretch
	a_result_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall) && !item_stall)
		else $error("result appeared outside the end of a tick");

	// no result can appear in the cycle right after a tick is accepted
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> !result_valid)
		else $error("result appeared right after a transaction");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(drive_first)
			&& $stable(drive_second) && $stable(pos_x) && $stable(pos_y)
			&& $stable(heading))
		else $error("stalled result changed");

endmodule

bind balance_feedback_with_odometry bfo_checker u_bfo_checker (.*);

`default_nettype wire

// File: sim/balance_feedback_with_odometry_tb.sv
// self-checking testbench for balance_feedback_with_odometry: directed ticks, random ticks, config sweeps
`timescale 1ns / 100ps

module balance_feedback_with_odometry_tb;
	import bfo_pkg::*;

	localparam int SINE_DEPTH = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 150;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic signed [15:0] wa;
		logic signed [15:0] wb;
		logic signed [15:0] pitch;
		logic signed [15:0] rate;
	} odo_tick_t;

	typedef struct {
		logic signed [31:0] drive_first;
		logic signed [31:0] drive_second;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0] heading;
	} odo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [15:0] wheel_speed_a = '0;
	logic signed [15:0] wheel_speed_b = '0;
	logic signed [15:0] pitch_angle = '0;
	logic signed [15:0] pitch_rate = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] drive_first;
	logic signed [31:0] drive_second;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0] heading;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state and its copy of the registers
	logic [15:0] sine_rom [SINE_DEPTH];
	logic [15:0] heading_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [15:0] gain_pos_q;
	logic signed [15:0] gain_pitch_q;
	logic signed [15:0] gain_wheel_q;
	logic signed [15:0] gain_rate_q;
	logic [15:0] period_q;

	odo_tick_t pending_ticks[$];
	odo_result_t predicted_ticks[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;

	balance_feedback_with_odometry #(
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.wheel_speed_a(wheel_speed_a),
		.wheel_speed_b(wheel_speed_b),
		.pitch_angle(pitch_angle),
		.pitch_rate(pitch_rate),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.drive_first(drive_first),
		.drive_second(drive_second),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// floor(v / 2^s + 1/2)
	function automatic longint round_half_up(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// quarter-wave rom filled by the odd power series of sin
	function automatic void build_sine_rom();
		longint x, term, acc, e;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x = HALF_PI_Q30 * longint'(i) / longint'(SINE_DEPTH);
			term = x;
			acc = x;
			for (int k = 1; k <= 6; k++) begin
				term = (term * x) / Q30_ONE;
				term = (term * x) / Q30_ONE;
				term = -term / longint'((2 * k) * (2 * k + 1));
				acc += term;
			end
			if (acc < 0)
				acc = 0;
			e = (acc + 64'sd16384) >>> 15;
			if (e > 32767)
				e = 32767;
			sine_rom[i] = e[15:0];
		end
	endfunction

	function automatic longint sine_q15(input logic [15:0] angle);
		int idx;
		longint mag;
		idx = (int'(angle[13:0]) * SINE_DEPTH) >>> 14;
		if (angle[14])
			idx = SINE_DEPTH - idx;
		// mirrored quadrant can land one past the table end: full scale
		mag = (idx >= SINE_DEPTH) ? longint'(SINE_FULL) : longint'(sine_rom[idx]);
		return angle[15] ? -mag : mag;
	endfunction

	function automatic odo_result_t advance_odometry(input odo_tick_t t);
		longint wa, wb, pitch, rate, dt, inc, vel, c, s, base;
		odo_result_t r;
		wa = t.wa;
		wb = t.wb;
		pitch = t.pitch;
		rate = t.rate;
		dt = longint'(period_q);
		inc = round_half_up((wa - wb) * dt * HEAD_K, 32);
		heading_q = heading_q + inc[15:0];
		vel = round_half_up(-(wa + wb) * dt * VEL_K, 24);
		c = sine_q15(heading_q + 16'd16384);
		s = sine_q15(heading_q);
		pos_x_q = clamp32(longint'(pos_x_q) + round_half_up(c * vel, 23));
		pos_y_q = clamp32(longint'(pos_y_q) + round_half_up(s * vel, 23));
		base = longint'(gain_pitch_q) * pitch * 16 + longint'(gain_rate_q) * rate * 256
			+ longint'(gain_pos_q) * longint'(pos_x_q);
		r.drive_first = clamp32(round_half_up(base + longint'(gain_wheel_q) * wb * 256, 8));
		r.drive_second = clamp32(round_half_up(base + longint'(gain_wheel_q) * wa * 256, 8));
		r.pos_x = pos_x_q;
		r.pos_y = pos_y_q;
		r.heading = heading_q;
		return r;
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (mismatch_count < 10)
			$display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
		mismatch_count++;
	endfunction

	// driver: a new tick goes out once the current one is taken
	always @(posedge clk or negedge arst_n) begin : tick_driver
		odo_tick_t nxt, taken;
		if (!arst_n) begin
			item_valid <= 1'b0;
			wheel_speed_a <= '0;
			wheel_speed_b <= '0;
			pitch_angle <= '0;
			pitch_rate <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				taken.wa = wheel_speed_a;
				taken.wb = wheel_speed_b;
				taken.pitch = pitch_angle;
				taken.rate = pitch_rate;
				predicted_ticks.insert(predicted_ticks.size(), advance_odometry(taken));
			end
			if (!item_valid || !item_stall) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_ticks.pop_front();
					wheel_speed_a <= nxt.wa;
					wheel_speed_b <= nxt.wb;
					pitch_angle <= nxt.pitch;
					pitch_rate <= nxt.rate;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: every result transaction is checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		odo_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (predicted_ticks.size() == 0) begin
					note_mismatch("unexpected result", '0, drive_first);
				end else begin
					want = predicted_ticks.pop_front();
					if (drive_first !== want.drive_first)
						note_mismatch("drive_first", want.drive_first, drive_first);
					if (drive_second !== want.drive_second)
						note_mismatch("drive_second", want.drive_second, drive_second);
					if (pos_x !== want.pos_x)
						note_mismatch("pos_x", want.pos_x, pos_x);
					if (pos_y !== want.pos_y)
						note_mismatch("pos_y", want.pos_y, pos_y);
					if (heading !== want.heading)
						note_mismatch("heading", {16'd0, want.heading}, {16'd0, heading});
				end
			end
			result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic void push_tick(input logic [15:0] wa, input logic [15:0] wb,
		input logic [15:0] pitch, input logic [15:0] rate);
		odo_tick_t t;
		t.wa = wa;
		t.wb = wb;
		t.pitch = pitch;
		t.rate = rate;
		pending_ticks.insert(pending_ticks.size(), t);
	endfunction

	function automatic void push_random_tick();
		odo_tick_t t;
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) begin
			t.wa = 16'(int'($urandom_range(1024)) - 512);
			t.wb = 16'(int'($urandom_range(1024)) - 512);
		end else if (pick < 7) begin
			// straight run, heading holds
			t.wa = 16'($urandom());
			t.wb = t.wa;
		end else begin
			t.wa = 16'($urandom());
			t.wb = 16'($urandom());
		end
		if ($urandom_range(1)) begin
			t.pitch = 16'(int'($urandom_range(4096)) - 2048);
			t.rate = 16'(int'($urandom_range(1024)) - 512);
		end else begin
			t.pitch = 16'($urandom());
			t.rate = 16'($urandom());
		end
		pending_ticks.insert(pending_ticks.size(), t);
	endfunction

	function automatic logic [15:0] random_gain();
		if ($urandom_range(1))
			return 16'(int'($urandom_range(2048)) - 1024);
		return 16'($urandom());
	endfunction

	function automatic void set_traffic(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 52; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 52; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
		endcase
	endfunction

	// returns right after a rising edge with the block drained
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || item_valid || predicted_ticks.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_GAIN_POSITION: gain_pos_q = data;
			REG_GAIN_PITCH: gain_pitch_q = data;
			REG_GAIN_WHEEL_SPEED: gain_wheel_q = data;
			REG_GAIN_PITCH_RATE: gain_rate_q = data;
			REG_TICK_PERIOD: period_q = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] gp, input logic [15:0] gpi,
		input logic [15:0] gw, input logic [15:0] gr, input logic [15:0] period);
		write_reg(REG_GAIN_POSITION, gp);
		write_reg(REG_GAIN_PITCH, gpi);
		write_reg(REG_GAIN_WHEEL_SPEED, gw);
		write_reg(REG_GAIN_PITCH_RATE, gr);
		write_reg(REG_TICK_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		build_sine_rom();
		heading_q = '0;
		pos_x_q = '0;
		pos_y_q = '0;
		gain_pos_q = RST_GAIN_POSITION;
		gain_pitch_q = RST_GAIN_PITCH;
		gain_wheel_q = RST_GAIN_WHEEL_SPEED;
		gain_rate_q = RST_GAIN_PITCH_RATE;
		period_q = RST_TICK_PERIOD;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks on reset settings
		set_traffic(0);
		push_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_tick(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		push_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_tick(16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		push_tick(16'h8000, 16'h7fff, 16'h0000, 16'h0000);
		push_tick(16'h0000, 16'h0000, 16'h7fff, 16'h8000);
		push_tick(16'h0000, 16'h0000, 16'h8000, 16'h7fff);
		push_tick(16'h5555, 16'h5555, 16'h5555, 16'h5555);
		push_tick(16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa);
		push_tick(16'h0001, 16'hffff, 16'h0001, 16'hffff);
		push_tick(16'hffff, 16'h0001, 16'hffff, 16'h0001);
		push_tick(16'h0100, 16'h0100, 16'h1000, 16'h0100);
		push_tick(16'h0064, 16'hff9c, 16'h0000, 16'h0000);
		push_tick(16'hff00, 16'hff00, 16'hf000, 16'hff00);
		wait_idle();

		// receiver holds off long enough for the block to back up
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (40) push_random_tick();
		wait_idle();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: ;
				1: configure(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
				2: configure(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
				3: begin
					// unknown index must be ignored; zero period freezes odometry
					write_reg(REG_UNUSED, 16'hffff);
					configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				end
				4: configure(RST_GAIN_POSITION, RST_GAIN_PITCH, RST_GAIN_WHEEL_SPEED,
					RST_GAIN_PITCH_RATE, RST_TICK_PERIOD);
				default: configure(random_gain(), random_gain(), random_gain(), random_gain(),
					$urandom_range(1) ? 16'($urandom_range(2000, 1))
						: 16'($urandom_range(65535, 1)));
			endcase
			set_traffic(phase);
			// full-speed straight run with equal wheel speeds, so heading holds
			if (phase == 1)
				repeat (40) push_tick(16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
			repeat (RANDOM_PER_PHASE) push_random_tick();
			wait_idle();
		end

		if (mismatch_count == 0 && predicted_ticks.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
